### rtl/fpc_pkg.sv
// shared constants for the frustum plane cull block
package fpc_pkg;

    localparam int NUM_PLANES = 6;

    localparam logic [2:0] CMD_LOAD_PROJ = 3'd0;
    localparam logic [2:0] CMD_LOAD_MV   = 3'd1;
    localparam logic [2:0] CMD_EXTRACT   = 3'd2;
    localparam logic [2:0] CMD_POINT     = 3'd3;
    localparam logic [2:0] CMD_VERTEX    = 3'd4;

endpackage

### rtl/fpc_plane_cell.sv
// one plane cell: holds one plane's coefficients and tests one point against it
module fpc_plane_cell #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  logic signed [32:0] load_a,
    input  logic signed [32:0] load_b,
    input  logic signed [32:0] load_c,
    input  logic signed [32:0] load_d,
    input  logic               in_valid,
    input  logic signed [31:0] in_x,
    input  logic signed [31:0] in_y,
    input  logic signed [31:0] in_z,
    input  logic               in_all_pos,
    output logic               out_valid,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z,
    output logic               out_all_pos,
    output logic               positive
);

    logic signed [32:0] a_reg, b_reg, c_reg, d_reg;
    logic signed [65:0] px_reg, py_reg, pz_reg;
    logic signed [67:0] sum;
    logic               valid_reg;
    logic               all_pos_reg;
    logic               pos_bit;
    logic signed [31:0] x_reg, y_reg, z_reg;

    always_ff @(posedge clk)
    begin
        px_reg <= 66'(a_reg * in_x);
        py_reg <= 66'(b_reg * in_y);
        pz_reg <= 66'(c_reg * in_z);
        x_reg  <= in_x;
        y_reg  <= in_y;
        z_reg  <= in_z;
        all_pos_reg <= in_all_pos;
    end

    // d aligned to the product fraction
    assign sum = 68'(px_reg) + 68'(py_reg) + 68'(pz_reg)
               + (68'(d_reg) <<< FRAC_BITS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            a_reg     <= '0;
            b_reg     <= '0;
            c_reg     <= '0;
            d_reg     <= '0;
        end
        else
        begin
            valid_reg <= in_valid;
            if (load)
            begin
                a_reg <= load_a;
                b_reg <= load_b;
                c_reg <= load_c;
                d_reg <= load_d;
            end
        end
    end

    assign pos_bit     = !sum[67] && (sum != 68'sd0);
    assign out_valid   = valid_reg;
    assign out_x       = x_reg;
    assign out_y       = y_reg;
    assign out_z       = z_reg;
    assign positive    = pos_bit;
    assign out_all_pos = all_pos_reg && pos_bit;

endmodule

### rtl/fpc_extract.sv
// matrix stores and sequential clip-entry and plane extraction
module fpc_extract #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_proj,
    input  logic               wr_mv,
    input  logic [3:0]         wr_index,
    input  logic signed [31:0] wr_value,
    input  logic               start,
    output logic               busy,
    output logic               plane_load,
    output logic [2:0]         plane_index,
    output logic signed [32:0] plane_a,
    output logic signed [32:0] plane_b,
    output logic signed [32:0] plane_c,
    output logic signed [32:0] plane_d
);

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_ACC, S_PLANE} state_t;

    logic signed [31:0] proj_reg [16];
    logic signed [31:0] mv_reg [16];
    logic signed [31:0] clip_reg [16];
    state_t             state_reg;
    logic [3:0]         entry_reg;
    logic [1:0]         k_reg;
    logic signed [63:0] prod_reg;
    logic signed [65:0] acc_reg;
    logic [2:0]         pidx_reg;
    logic               load_reg;
    logic signed [65:0] acc_next;
    logic signed [65:0] shifted;
    logic signed [31:0] sat;
    logic [1:0]         row, col;
    logic signed [32:0] w0, w1, w2, w3, e0, e1, e2, e3;
    logic [1:0]         axis;

    assign row = entry_reg[3:2];
    assign col = entry_reg[1:0];
    // four exact products summed, then floored once
    assign acc_next = acc_reg + 66'(prod_reg);
    assign shifted  = acc_next >>> FRAC_BITS;
    assign sat = (shifted > 66'sd2147483647) ? 32'sh7fffffff :
                 (shifted < -66'sd2147483648) ? 32'sh80000000 : shifted[31:0];

    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(mv_reg[{row, k_reg}] * proj_reg[{k_reg, col}]);
    end

    always_comb
    begin
        axis = (pidx_reg[2:1] == 2'd0) ? 2'd0 : (pidx_reg[2:1] == 2'd1) ? 2'd1 : 2'd2;
        w0 = 33'(clip_reg[3]);
        w1 = 33'(clip_reg[7]);
        w2 = 33'(clip_reg[11]);
        w3 = 33'(clip_reg[15]);
        e0 = 33'(clip_reg[{2'd0, axis}]);
        e1 = 33'(clip_reg[{2'd1, axis}]);
        e2 = 33'(clip_reg[{2'd2, axis}]);
        e3 = 33'(clip_reg[{2'd3, axis}]);
        // right, bottom-swapped pattern: right -, left +, bottom +, top -, far -, near +
        if (pidx_reg == 3'd0 || pidx_reg == 3'd3 || pidx_reg == 3'd4)
        begin
            plane_a = w0 - e0;
            plane_b = w1 - e1;
            plane_c = w2 - e2;
            plane_d = w3 - e3;
        end
        else
        begin
            plane_a = w0 + e0;
            plane_b = w1 + e1;
            plane_c = w2 + e2;
            plane_d = w3 + e3;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            entry_reg <= '0;
            k_reg     <= '0;
            acc_reg   <= '0;
            pidx_reg  <= '0;
            load_reg  <= 1'b0;
            for (int i = 0; i < 16; i++)
            begin
                clip_reg[i] <= '0;
                proj_reg[i] <= '0;
                mv_reg[i]   <= '0;
            end
        end
        else
        begin
            if (wr_proj)
                proj_reg[wr_index] <= wr_value;
            if (wr_mv)
                mv_reg[wr_index] <= wr_value;
            load_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_MUL;
                        entry_reg <= '0;
                        k_reg     <= '0;
                        acc_reg   <= '0;
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    if (k_reg == 2'd3)
                    begin
                        clip_reg[entry_reg] <= sat;
                        acc_reg <= '0;
                        k_reg   <= '0;
                        if (entry_reg == 4'd15)
                        begin
                            state_reg <= S_PLANE;
                            pidx_reg  <= '0;
                        end
                        else
                        begin
                            entry_reg <= entry_reg + 4'd1;
                            state_reg <= S_MUL;
                        end
                    end
                    else
                    begin
                        acc_reg   <= acc_next;
                        k_reg     <= k_reg + 2'd1;
                        state_reg <= S_MUL;
                    end
                end
                S_PLANE:
                begin
                    load_reg <= 1'b1;
                    if (load_reg)
                    begin
                        if (pidx_reg == 3'd5)
                            state_reg <= S_IDLE;
                        else
                            pidx_reg <= pidx_reg + 3'd1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign plane_load  = load_reg;
    assign plane_index = pidx_reg;

endmodule

### rtl/frustum_plane_cull.sv
// top level of the frustum plane cull block
// A point test or rectangle vertex passes through a chain of six plane cells,
// one per frustum plane, each holding its plane coefficients and three
// multipliers; the next test is taken once the last one has left the chain
// and the result register is free (a vertex that closes no rectangle frees
// the input once it leaves the chain). A matrix load is written when it is
// taken. An extract computes the sixteen clip entries with one shared
// multiplier, registering each product before it is accumulated, then writes
// one plane per cycle; no item is taken while it runs.
module frustum_plane_cull #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid_in,
    output logic               ready_in,
    input  logic [2:0]         command,
    input  logic [3:0]         element_index,
    input  logic signed [31:0] element_value,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_y,
    input  logic signed [31:0] coord_z,
    output logic               valid_out,
    input  logic               ready_out,
    output logic               visible,
    output logic               test_kind
);

    localparam int NP = fpc_pkg::NUM_PLANES;

    logic               acc;
    logic               busy;
    logic               plane_load;
    logic [2:0]         plane_index;
    logic signed [32:0] pa, pb, pc, pd;
    logic               test_busy_reg;
    logic               is_vertex_reg;
    logic [NP:0]        cv;
    logic signed [31:0] cx [NP+1];
    logic signed [31:0] cy [NP+1];
    logic signed [31:0] cz [NP+1];
    logic [NP:0]        cap;
    logic [NP-1:0]      pos;
    logic [NP-1:0]      pos_pipe_reg [NP];
    logic [NP-1:0]      seen_reg;
    logic [1:0]         vcount_reg;
    logic               out_valid_reg;
    logic               vis_reg, kind_reg;
    logic [NP-1:0]      seen_next;

    assign ready_in = !busy && !test_busy_reg && !out_valid_reg;
    assign acc = valid_in && ready_in;

    fpc_extract #(.FRAC_BITS(FRAC_BITS)) u_extract (
        .clk(clk), .rst_n(rst_n),
        .wr_proj(acc && command == fpc_pkg::CMD_LOAD_PROJ),
        .wr_mv(acc && command == fpc_pkg::CMD_LOAD_MV),
        .wr_index(element_index), .wr_value(element_value),
        .start(acc && command == fpc_pkg::CMD_EXTRACT),
        .busy(busy), .plane_load(plane_load), .plane_index(plane_index),
        .plane_a(pa), .plane_b(pb), .plane_c(pc), .plane_d(pd)
    );

    assign cv[0]  = acc && (command == fpc_pkg::CMD_POINT || command == fpc_pkg::CMD_VERTEX);
    assign cx[0]  = coord_x;
    assign cy[0]  = coord_y;
    assign cz[0]  = coord_z;
    assign cap[0] = 1'b1;

    genvar g;
    generate
        for (g = 0; g < NP; g++)
        begin : g_cell
            fpc_plane_cell #(.FRAC_BITS(FRAC_BITS)) u_cell (
                .clk(clk), .rst_n(rst_n),
                .load(plane_load && plane_index == 3'(g)),
                .load_a(pa), .load_b(pb), .load_c(pc), .load_d(pd),
                .in_valid(cv[g]), .in_x(cx[g]), .in_y(cy[g]), .in_z(cz[g]),
                .in_all_pos(cap[g]),
                .out_valid(cv[g+1]), .out_x(cx[g+1]), .out_y(cy[g+1]),
                .out_z(cz[g+1]), .out_all_pos(cap[g+1]), .positive(pos[g])
            );
        end
    endgenerate

    // per-plane sign bits travel with the item down the chain
    always_ff @(posedge clk)
    begin
        pos_pipe_reg[0] <= '0;
        for (int i = 1; i < NP; i++)
            pos_pipe_reg[i] <= pos_pipe_reg[i-1] | (NP'(pos[i-1]) << (i-1));
    end

    assign seen_next = seen_reg | pos_pipe_reg[NP-1] | (NP'(pos[NP-1]) << (NP-1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            test_busy_reg <= 1'b0;
            is_vertex_reg <= 1'b0;
            seen_reg      <= '0;
            vcount_reg    <= '0;
            out_valid_reg <= 1'b0;
            vis_reg       <= 1'b0;
            kind_reg      <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && ready_out)
                out_valid_reg <= 1'b0;
            if (cv[0])
            begin
                test_busy_reg <= 1'b1;
                is_vertex_reg <= (command == fpc_pkg::CMD_VERTEX);
            end
            if (cv[NP])
            begin
                test_busy_reg <= 1'b0;
                if (!is_vertex_reg)
                begin
                    out_valid_reg <= 1'b1;
                    vis_reg       <= cap[NP];
                    kind_reg      <= 1'b0;
                end
                else if (vcount_reg == 2'd3)
                begin
                    out_valid_reg <= 1'b1;
                    vis_reg       <= (seen_next == {NP{1'b1}});
                    kind_reg      <= 1'b1;
                    seen_reg      <= '0;
                    vcount_reg    <= '0;
                end
                else
                begin
                    seen_reg   <= seen_next;
                    vcount_reg <= vcount_reg + 2'd1;
                end
            end
        end
    end

    assign valid_out = out_valid_reg;
    assign visible   = vis_reg;
    assign test_kind = kind_reg;

endmodule

### bench/tb_top.sv
// self-checking testbench for the frustum plane cull block
`timescale 1ns / 100ps

module tb_top;

    localparam int FRAC = 16;
    localparam int STALL_LIMIT = 4000;
    localparam int RANDOM_ITEMS = 400;
    localparam logic [2:0] CMD_SPARE_LO = 3'd5;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;
    localparam logic signed [31:0] ONE = 32'sh0001_0000;
    localparam logic signed [31:0] MAXV = 32'sh7fff_ffff;
    localparam logic signed [31:0] MINV = 32'sh8000_0000;

    typedef struct {
        logic [2:0]         cmd;
        logic [3:0]         idx;
        logic signed [31:0] val;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } cull_item_t;

    typedef struct {
        cull_item_t item;
        bit         typed;
        bit         vis;
        bit         kind;
    } table_row_t;

    typedef struct {
        bit vis;
        bit kind;
    } verdict_t;

    logic               clk;
    logic               rst_n;
    logic               valid_in;
    logic               ready_in;
    logic [2:0]         command;
    logic [3:0]         element_index;
    logic signed [31:0] element_value;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic               valid_out;
    logic               ready_out;
    logic               visible;
    logic               test_kind;

    longint   proj_m[16];
    longint   mv_m[16];
    longint   planes[24];
    bit [5:0] seen_pos;
    int       vtx_count;

    verdict_t verdict_q[$];
    table_row_t directed[$];
    int phase;
    int mismatches;
    int verdicts_seen;
    int points_seen;
    int rects_seen;
    int idle_cycles;

    frustum_plane_cull #(.FRAC_BITS(FRAC)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .valid_in(valid_in),
        .ready_in(ready_in),
        .command(command),
        .element_index(element_index),
        .element_value(element_value),
        .coord_x(coord_x),
        .coord_y(coord_y),
        .coord_z(coord_z),
        .valid_out(valid_out),
        .ready_out(ready_out),
        .visible(visible),
        .test_kind(test_kind)
    );

    always #10 clk = ~clk;

    function automatic longint clip_entry(int r, int c);
        logic signed [95:0] acc;
        logic signed [95:0] a;
        logic signed [95:0] b;
        acc = '0;
        for (int k = 0; k < 4; k++)
        begin
            a = mv_m[4 * r + k];
            b = proj_m[4 * k + c];
            acc = acc + a * b;
        end
        acc = acc >>> FRAC;
        if (acc > 96'sd2147483647)
            acc = 96'sd2147483647;
        if (acc < -96'sd2147483648)
            acc = -96'sd2147483648;
        return longint'(acc);
    endfunction

    function automatic void extract_planes();
        longint clip[16];
        longint w;
        for (int i = 0; i < 16; i++)
            clip[i] = clip_entry(i / 4, i % 4);
        for (int j = 0; j < 4; j++)
        begin
            w = clip[4 * j + 3];
            planes[j]      = w - clip[4 * j];
            planes[4 + j]  = w + clip[4 * j];
            planes[8 + j]  = w + clip[4 * j + 1];
            planes[12 + j] = w - clip[4 * j + 1];
            planes[16 + j] = w - clip[4 * j + 2];
            planes[20 + j] = w + clip[4 * j + 2];
        end
    endfunction

    function automatic bit [5:0] positive_planes(cull_item_t it);
        logic signed [95:0] s;
        logic signed [95:0] c0;
        logic signed [95:0] c1;
        logic signed [95:0] c2;
        logic signed [95:0] c3;
        bit [5:0] m;
        m = '0;
        for (int p = 0; p < fpc_pkg::NUM_PLANES; p++)
        begin
            c0 = planes[4 * p];
            c1 = planes[4 * p + 1];
            c2 = planes[4 * p + 2];
            c3 = planes[4 * p + 3];
            s = c0 * 96'(it.x) + c1 * 96'(it.y) + c2 * 96'(it.z) + (c3 <<< FRAC);
            m[p] = (s > 0);
        end
        return m;
    endfunction

    function automatic void cull_step(cull_item_t it, output bit has, output verdict_t v);
        bit [5:0] m;
        has = 0;
        v = '{vis: 0, kind: 0};
        case (it.cmd)
            fpc_pkg::CMD_LOAD_PROJ: proj_m[it.idx] = it.val;
            fpc_pkg::CMD_LOAD_MV:   mv_m[it.idx] = it.val;
            fpc_pkg::CMD_EXTRACT:   extract_planes();
            fpc_pkg::CMD_POINT:
            begin
                has = 1;
                v.vis = (positive_planes(it) == 6'h3f);
            end
            fpc_pkg::CMD_VERTEX:
            begin
                seen_pos = seen_pos | positive_planes(it);
                if (vtx_count == 3)
                begin
                    has = 1;
                    v.vis = (seen_pos == 6'h3f);
                    v.kind = 1;
                    seen_pos = '0;
                    vtx_count = 0;
                end
                else
                    vtx_count++;
            end
            default: ;
        endcase
    endfunction

    function automatic logic signed [31:0] rand_fixed();
        if ($urandom_range(0, 9) < 7)
            return $signed($urandom_range(0, 524288)) - 32'sd262144;
        return $urandom;
    endfunction

    function automatic cull_item_t mk(logic [2:0] cmd, logic [3:0] idx,
                                      logic signed [31:0] val,
                                      logic signed [31:0] x, logic signed [31:0] y,
                                      logic signed [31:0] z);
        cull_item_t it;
        it.cmd = cmd;
        it.idx = idx;
        it.val = val;
        it.x = x;
        it.y = y;
        it.z = z;
        return it;
    endfunction

    function automatic void add_row(cull_item_t it, bit typed, bit vis, bit kind);
        table_row_t r;
        r.item = it;
        r.typed = typed;
        r.vis = vis;
        r.kind = kind;
        directed.push_back(r);
    endfunction

    task automatic send_item(cull_item_t it, bit typed, verdict_t typed_v);
        bit has;
        verdict_t v;
        if ((phase == 1 || phase == 3) && $urandom_range(0, 99) < (phase == 1 ? 80 : 8))
        begin
            valid_in <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        valid_in <= 1'b1;
        command <= it.cmd;
        element_index <= it.idx;
        element_value <= it.val;
        coord_x <= it.x;
        coord_y <= it.y;
        coord_z <= it.z;
        do
            @(posedge clk);
        while (!(valid_in && ready_in));
        cull_step(it, has, v);
        if (has)
            verdict_q.push_back(typed ? typed_v : v);
    endtask

    task automatic random_item();
        cull_item_t it;
        int sel;
        sel = $urandom_range(0, 99);
        it = mk(fpc_pkg::CMD_POINT, 4'($urandom), $urandom, rand_fixed(), rand_fixed(),
                rand_fixed());
        if (sel < 12)
        begin
            it.cmd = fpc_pkg::CMD_LOAD_PROJ;
            it.val = rand_fixed();
        end
        else if (sel < 24)
        begin
            it.cmd = fpc_pkg::CMD_LOAD_MV;
            it.val = rand_fixed();
        end
        else if (sel < 28)
            it.cmd = fpc_pkg::CMD_EXTRACT;
        else if (sel < 60)
            it.cmd = fpc_pkg::CMD_POINT;
        else if (sel < 96)
            it.cmd = fpc_pkg::CMD_VERTEX;
        else
            it.cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
        send_item(it, 0, '{vis: 0, kind: 0});
    endtask

    // response side: stall control, checking and watchdog
    always @(posedge clk)
    begin
        verdict_t exp_v;
        if (!rst_n)
            idle_cycles <= 0;
        else
        begin
            if ((valid_in && ready_in) || (valid_out && ready_out))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("tb_top: FAIL");
                $finish;
            end
            if (valid_out && ready_out)
            begin
                if (verdict_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result visible=%0b kind=%0b", visible, test_kind);
                end
                else
                begin
                    exp_v = verdict_q.pop_front();
                    verdicts_seen++;
                    if (exp_v.kind)
                        rects_seen++;
                    else
                        points_seen++;
                    if (visible !== exp_v.vis || test_kind !== exp_v.kind)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch #%0d: visible exp %0b got %0b, kind exp %0b got %0b",
                                     verdicts_seen, exp_v.vis, visible, exp_v.kind, test_kind);
                    end
                end
            end
            if (phase == 2)
                ready_out <= ($urandom_range(0, 99) >= 80);
            else if (phase == 3)
                ready_out <= ($urandom_range(0, 99) >= 8);
            else
                ready_out <= 1'b1;
        end
    end

    initial
    begin
        clk = 0;
        rst_n = 0;
        valid_in = 0;
        ready_out = 0;
        command = fpc_pkg::CMD_LOAD_PROJ;
        element_index = '0;
        element_value = '0;
        coord_x = '0;
        coord_y = '0;
        coord_z = '0;
        phase = 0;
        mismatches = 0;
        verdicts_seen = 0;
        points_seen = 0;
        rects_seen = 0;
        seen_pos = '0;
        vtx_count = 0;
        for (int i = 0; i < 16; i++)
        begin
            proj_m[i] = 0;
            mv_m[i] = 0;
        end
        for (int i = 0; i < 24; i++)
            planes[i] = 0;

        // zero planes report outside
        add_row(mk(fpc_pkg::CMD_POINT, 0, 0, 0, 0, 0), 1, 0, 0);
        add_row(mk(fpc_pkg::CMD_VERTEX, 0, 0, MAXV, MAXV, MAXV), 0, 0, 0);
        add_row(mk(fpc_pkg::CMD_VERTEX, 0, 0, MINV, MINV, MINV), 0, 0, 0);
        add_row(mk(fpc_pkg::CMD_VERTEX, 0, 0, 0, 0, 0), 0, 0, 0);
        add_row(mk(fpc_pkg::CMD_VERTEX, 0, 0, ONE, 0, 0), 1, 0, 1);
        add_row(mk(CMD_SPARE_LO, 4'hf, MAXV, MAXV, MAXV, MAXV), 0, 0, 0);
        add_row(mk(CMD_SPARE_HI, 4'h0, MINV, MINV, MINV, MINV), 0, 0, 0);
        // identity projection and modelview
        for (int i = 0; i < 4; i++)
        begin
            add_row(mk(fpc_pkg::CMD_LOAD_PROJ, 4'(5 * i), ONE, 0, 0, 0), 0, 0, 0);
            add_row(mk(fpc_pkg::CMD_LOAD_MV, 4'(5 * i), ONE, 0, 0, 0), 0, 0, 0);
        end
        add_row(mk(fpc_pkg::CMD_EXTRACT, 0, 0, 0, 0, 0), 0, 0, 0);
        add_row(mk(fpc_pkg::CMD_POINT, 0, 0, 0, 0, 0), 1, 1, 0);
        add_row(mk(fpc_pkg::CMD_POINT, 0, 0, MAXV, 0, 0), 1, 0, 0);
        // point test, matrix loads and extract in the middle of a rectangle
        add_row(mk(fpc_pkg::CMD_VERTEX, 0, 0, 32'sh8000, 0, 0), 0, 0, 0);
        add_row(mk(fpc_pkg::CMD_POINT, 0, 0, MINV, MINV, MINV), 1, 0, 0);
        add_row(mk(fpc_pkg::CMD_VERTEX, 0, 0, -32'sh8000, 0, 0), 0, 0, 0);
        add_row(mk(fpc_pkg::CMD_LOAD_PROJ, 4'h3, MAXV, 0, 0, 0), 0, 0, 0);
        add_row(mk(fpc_pkg::CMD_LOAD_MV, 4'hc, MINV, 0, 0, 0), 0, 0, 0);
        add_row(mk(fpc_pkg::CMD_EXTRACT, 0, 0, 0, 0, 0), 0, 0, 0);
        add_row(mk(fpc_pkg::CMD_VERTEX, 0, 0, 0, ONE, 0), 0, 0, 0);
        add_row(mk(fpc_pkg::CMD_VERTEX, 0, 0, 0, 0, MAXV), 0, 0, 0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_item(directed[i].item, directed[i].typed,
                      '{vis: directed[i].vis, kind: directed[i].kind});

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            phase = n / (RANDOM_ITEMS / 4);
            random_item();
        end
        valid_in <= 1'b0;
        phase = 0;

        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("covered %0d directed and %0d random items over four handshake phases",
                 directed.size(), RANDOM_ITEMS);
        $display("checked %0d point and %0d rectangle verdicts, %0d mismatches",
                 points_seen, rects_seen, mismatches);
        if (mismatches == 0 && verdict_q.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
